/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spiral generator assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/soag_pkg.sv */
// types and constants of the spiral order address generator
package soag_pkg;

    localparam int DEFAULT_MAX_DIM = 32;

    localparam int DIM_W      = 6;
    localparam int POS_W      = 5;
    localparam int VALUE_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSION         = 2'd0,
        CFG_START_DIRECTION   = 2'd1,
        CFG_COUNTER_CLOCKWISE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] dimension;
        dir_t             start_direction;
        logic             counter_clockwise;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
    } result_t;

endpackage

/* rtl/soag_core.sv */
// spiral walk state and next-cell logic
module soag_core
    import soag_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    restart,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int LEG_W = (MAX_DIM <= 2) ? 1 : $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    dir_t             heading_reg, heading_next;
    logic [LEG_W-1:0] leg_reg, leg_next;
    logic [LEG_W-1:0] steps_reg, steps_next;
    logic [1:0]       legs_at_reg, legs_at_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             active_reg, active_next;

    logic [DIM_W-1:0]   n;
    logic [2*DIM_W-1:0] nn;
    logic [CNT_W-1:0]   total;
    logic [POS_W-1:0]   h;
    logic [POS_W-1:0]   hm1;
    logic [LEG_W-1:0]   steps_dec;
    logic [1:0]         legs_inc;
    logic               grow;
    logic               last;

    // clamp side length into 1..MAX_DIM
    always_comb
    begin
        if (cfg.dimension == '0)
        begin
            n = DIM_W'(1);
        end
        else if ({1'b0, cfg.dimension} > (DIM_W+1)'(MAX_DIM))
        begin
            n = DIM_W'(MAX_DIM);
        end
        else
        begin
            n = cfg.dimension;
        end
    end

    assign nn    = n * n;
    assign total = CNT_W'(nn);
    assign h     = POS_W'(n >> 1);
    assign hm1   = h - POS_W'(1);

    assign steps_dec = steps_reg - LEG_W'(1);
    assign legs_inc  = legs_at_reg + 2'd1;
    assign grow      = ((DIM_W+1)'(leg_reg) + (DIM_W+1)'(1)) < (DIM_W+1)'(n);

    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        heading_next = heading_reg;
        leg_next     = leg_reg;
        steps_next   = steps_reg;
        legs_at_next = legs_at_reg;
        count_next   = count_reg;
        last         = 1'b0;

        if (restart)
        begin
            row_next = h;
            col_next = h;
            // even side: pick one of the four central cells
            if (!n[0])
            begin
                unique case (cfg.start_direction)
                    DIR_LEFT:
                    begin
                        col_next = h;
                        row_next = cfg.counter_clockwise ? hm1 : h;
                    end
                    DIR_UP:
                    begin
                        row_next = h;
                        col_next = cfg.counter_clockwise ? h : hm1;
                    end
                    DIR_RIGHT:
                    begin
                        col_next = hm1;
                        row_next = cfg.counter_clockwise ? h : hm1;
                    end
                    default:
                    begin
                        row_next = hm1;
                        col_next = cfg.counter_clockwise ? hm1 : h;
                    end
                endcase
            end
            heading_next = cfg.start_direction;
            leg_next     = LEG_W'(1);
            steps_next   = LEG_W'(1);
            legs_at_next = 2'd0;
            count_next   = CNT_W'(1);
            last         = (n == DIM_W'(1));
        end
        else
        begin
            unique case (heading_reg)
                DIR_LEFT:  col_next = col_reg - POS_W'(1);
                DIR_UP:    row_next = row_reg - POS_W'(1);
                DIR_RIGHT: col_next = col_reg + POS_W'(1);
                default:   row_next = row_reg + POS_W'(1);
            endcase
            count_next = count_reg + CNT_W'(1);

            if (steps_dec == '0)
            begin
                if (cfg.counter_clockwise)
                begin
                    heading_next = dir_t'(heading_reg - 2'd1);
                end
                else
                begin
                    heading_next = dir_t'(heading_reg + 2'd1);
                end
                legs_at_next = legs_inc;
                leg_next     = leg_reg;
                if (legs_inc == 2'd2 && grow)
                begin
                    leg_next     = leg_reg + LEG_W'(1);
                    legs_at_next = 2'd0;
                end
                steps_next = leg_next;
            end
            else
            begin
                steps_next = steps_dec;
            end
            last = (count_next >= total);
        end

        active_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            heading_reg <= DIR_LEFT;
            leg_reg     <= LEG_W'(1);
            steps_reg   <= LEG_W'(1);
            legs_at_reg <= 2'd0;
            count_reg   <= '0;
            active_reg  <= 1'b0;
        end
        else if (step && (restart || active_reg))
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            heading_reg <= heading_next;
            leg_reg     <= leg_next;
            steps_reg   <= steps_next;
            legs_at_reg <= legs_at_next;
            count_reg   <= count_next;
            active_reg  <= active_next;
        end
    end

    assign res.valid = restart || active_reg;
    assign res.last  = last;
    assign res.value = VALUE_W'(count_next);
    assign res.col   = col_next;
    assign res.row   = row_next;

endmodule

/* rtl/spiral_order_address_generator_top.sv */
// top level of the center-out spiral order address generator
//
// each input transfer on the s_ channel is one tick: restart=1 emits the
// start cell of a new spiral with value 1, restart=0 emits the next cell
// each result leaves on the m_ channel as row, col and value, with tlast
// set on the final cell of the square
// a restart=0 tick while no spiral runs (after reset or after the final
// cell) is taken but yields no result transfer
// the result is registered: a tick accepted at one edge shows its result on
// m_tvalid after that edge; one tick per cycle is sustained while m_tready
// stays high, the walk state and the result register set that figure
// when the receiver stalls, the result register holds and s_tready drops
// until the held result is taken
// the cfg_ channel writes dimension, start_direction and
// counter_clockwise; it is always ready
// reset clears the walk to idle, empties the result register and sets
// dimension 1, start direction left and clockwise turns
`include "assert_macros.svh"

module spiral_order_address_generator_top
    import soag_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // restart, zeros

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // row, col, value, zeros
    output logic                  m_tlast,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg;
    logic    m_tvalid_reg;
    logic    s_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dimension         <= DIM_W'(1);
            cfg_reg.start_direction   <= DIR_LEFT;
            cfg_reg.counter_clockwise <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DIMENSION:         cfg_reg.dimension <= cfg_data[DIM_W-1:0];
                CFG_START_DIRECTION:   cfg_reg.start_direction <= dir_t'(cfg_data[1:0]);
                CFG_COUNTER_CLOCKWISE: cfg_reg.counter_clockwise <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    soag_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s_accept),
        .restart (s_tdata[0]),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            m_tvalid_reg <= res.valid;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {(M_TDATA_W - VALUE_W - 2*POS_W)'(0),
                       out_reg.value, out_reg.col, out_reg.row};

    // restart always yields the first cell
    `ASSERT_PROP(a_restart_first, clk, rst_n,
        (s_accept && s_tdata[0]) |=> (m_tvalid && out_reg.value == VALUE_W'(1)))

    // after the final cell an advance yields nothing
    `ASSERT_NEVER(a_idle_after_last, clk, rst_n,
        $past(m_tvalid && m_tlast && m_tready && s_accept && !s_tdata[0]) && m_tvalid)

    // an advance mid-spiral yields the next number
    `ASSERT_PROP(a_value_step, clk, rst_n,
        (m_tvalid && !m_tlast && m_tready && s_accept && !s_tdata[0]) |=>
        (m_tvalid && out_reg.value == VALUE_W'($past(out_reg.value) + VALUE_W'(1))))

endmodule

/* tb/spiral_order_address_generator_top_tb.sv */
// testbench of the spiral order address generator against a predicted walk
`timescale 1ns / 1ps

module spiral_order_address_generator_top_tb;
    import soag_pkg::*;

    typedef struct {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } grid_pos_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copies
    logic [DIM_W-1:0] cfg_dim = 6'd1;
    dir_t             cfg_dir = DIR_LEFT;
    logic             cfg_ccw = 1'b0;

    // walk state
    logic [5:0]  walk_row = '0;
    logic [5:0]  walk_col = '0;
    dir_t        walk_heading = DIR_LEFT;
    logic [5:0]  leg_len = 6'd1;
    logic [5:0]  steps_left = 6'd1;
    logic [1:0]  legs_done = '0;
    logic [15:0] cell_no = '0;
    bit          walking = 1'b0;

    grid_pos_t pending_cells[$];
    int        predicted_cells = 0;
    int        mismatch_count = 0;
    int        hold_left = 0;
    bit        steady = 1'b0;

    spiral_order_address_generator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // restart, zeros
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // row, col, value, zeros
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #4_000_000;
        $display("spiral_order_address_generator_top_tb NOT OK");
        $finish;
    end

    function automatic int side_now();
        int n;
        n = cfg_dim;
        if (n < 1)
            n = 1;
        if (n > DEFAULT_MAX_DIM)
            n = DEFAULT_MAX_DIM;
        return n;
    endfunction

    task automatic predict_tick(input bit restart);
        int n;
        int total;
        int h;
        int r;
        int c;
        grid_pos_t want;
        n = side_now();
        total = n * n;
        h = n / 2;
        if (restart)
        begin
            r = h;
            c = h;
            if (n % 2 == 0)
            begin
                case (cfg_dir)
                    DIR_LEFT:  r = cfg_ccw ? h - 1 : h;
                    DIR_UP:    c = cfg_ccw ? h : h - 1;
                    DIR_RIGHT:
                    begin
                        c = h - 1;
                        r = cfg_ccw ? h : h - 1;
                    end
                    default:
                    begin
                        r = h - 1;
                        c = cfg_ccw ? h - 1 : h;
                    end
                endcase
            end
            walk_row = 6'(r);
            walk_col = 6'(c);
            walk_heading = cfg_dir;
            leg_len = 6'd1;
            steps_left = 6'd1;
            legs_done = 2'd0;
            cell_no = 16'd1;
        end
        else if (!walking)
            return;
        else
        begin
            case (walk_heading)
                DIR_LEFT:  walk_col = walk_col - 6'd1;
                DIR_UP:    walk_row = walk_row - 6'd1;
                DIR_RIGHT: walk_col = walk_col + 6'd1;
                default:   walk_row = walk_row + 6'd1;
            endcase
            cell_no = cell_no + 16'd1;
            steps_left = steps_left - 6'd1;
            if (steps_left == 6'd0)
            begin
                walk_heading = cfg_ccw ? dir_t'(walk_heading - 2'd1)
                                       : dir_t'(walk_heading + 2'd1);
                legs_done = legs_done + 2'd1;
                if (legs_done == 2'd2 && int'(leg_len) + 1 < n)
                begin
                    leg_len = leg_len + 6'd1;
                    legs_done = 2'd0;
                end
                if (leg_len == 6'd0)
                    leg_len = 6'd1;
                steps_left = leg_len;
            end
        end
        walking = !(int'(cell_no) >= total);
        want.row = walk_row[POS_W-1:0];
        want.col = walk_col[POS_W-1:0];
        want.value = cell_no[VALUE_W-1:0];
        want.last = !walking;
        pending_cells.push_back(want);
        predicted_cells++;
    endtask

    // called at a rising edge; leaves tvalid high after the transfer
    task automatic send_tick(input bit restart);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 29)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-1){1'b0}}, restart};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        predict_tick(restart);
    endtask

    task automatic send_advances(input int count);
        repeat (count) send_tick(1'b0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DIMENSION:       cfg_dim = data;
            CFG_START_DIRECTION: cfg_dir = dir_t'(data[1:0]);
            default:             cfg_ccw = data[0];
        endcase
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int k;
        k = $urandom_range(99);
        if (k < 75)
            return CFG_DATA_W'($urandom_range(6, 1));
        if (k < 90)
            return CFG_DATA_W'($urandom_range(12, 7));
        if (k < 95)
            return CFG_DATA_W'($urandom_range(32, 13));
        return $urandom_range(1) ? '0 : CFG_DATA_W'($urandom_range(63, 33));
    endfunction

    task automatic write_any_reg();
        cfg_index_t idx;
        idx = cfg_index_t'($urandom_range(2));
        write_reg(idx, idx == CFG_DIMENSION ? pick_dim() : CFG_DATA_W'($urandom_range(63)));
    endtask

    task automatic test_idle_advance();
        send_advances(2);
        send_tick(1'b1);
        send_advances(1);
        settle();
    endtask

    task automatic test_start_cells();
        write_reg(CFG_DIMENSION, 6'd4);
        for (int d = 0; d < 4; d++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                write_reg(CFG_START_DIRECTION, CFG_DATA_W'(d));
                write_reg(CFG_COUNTER_CLOCKWISE, CFG_DATA_W'(s));
                send_tick(1'b1);
                settle();
            end
        end
    endtask

    task automatic test_small_square();
        write_reg(CFG_DIMENSION, 6'd2);
        write_reg(CFG_START_DIRECTION, CFG_DATA_W'(DIR_DOWN));
        write_reg(CFG_COUNTER_CLOCKWISE, 6'd1);
        send_tick(1'b1);
        send_advances(4);
        settle();
    endtask

    task automatic test_range_clamp();
        write_reg(CFG_DIMENSION, 6'd0);
        send_tick(1'b1);
        send_advances(1);
        settle();
        write_reg(CFG_DIMENSION, 6'd63);
        send_tick(1'b1);
        send_advances(2);
        send_tick(1'b1);
        send_advances(1);
        settle();
    endtask

    task automatic test_live_registers();
        write_reg(CFG_DIMENSION, 6'd4);
        write_reg(CFG_START_DIRECTION, CFG_DATA_W'(DIR_LEFT));
        write_reg(CFG_COUNTER_CLOCKWISE, 6'd0);
        send_tick(1'b1);
        send_advances(5);
        settle();
        // shrink and flip sense mid-walk
        write_reg(CFG_COUNTER_CLOCKWISE, 6'd1);
        write_reg(CFG_DIMENSION, 6'd2);
        send_advances(2);
        settle();
        // grow mid-walk so the walk leaves the square and wraps
        send_tick(1'b1);
        send_advances(1);
        settle();
        write_reg(CFG_DIMENSION, 6'd32);
        send_advances(24);
        settle();
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        write_reg(CFG_DIMENSION, 6'd16);
        write_reg(CFG_START_DIRECTION, CFG_DATA_W'(DIR_UP));
        write_reg(CFG_COUNTER_CLOCKWISE, 6'd0);
        send_tick(1'b1);
        send_advances(255);
        settle();
        steady = 1'b0;
    endtask

    task automatic test_back_pressure();
        write_reg(CFG_DIMENSION, 6'd32);
        write_reg(CFG_START_DIRECTION, CFG_DATA_W'(DIR_RIGHT));
        send_tick(1'b1);
        hold_left = 200;
        send_advances(60);
        settle();
    endtask

    task automatic test_random();
        int target;
        int kind;
        int k;
        int guard;
        target = predicted_cells + 1350;
        while (predicted_cells < target)
        begin
            settle();
            if ($urandom_range(99) < 80)
                write_reg(CFG_DIMENSION, pick_dim());
            if ($urandom_range(99) < 50)
                write_reg(CFG_START_DIRECTION, CFG_DATA_W'($urandom_range(63)));
            if ($urandom_range(99) < 50)
                write_reg(CFG_COUNTER_CLOCKWISE, CFG_DATA_W'($urandom_range(63)));
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                k = side_now() * side_now() - 1 + $urandom_range(2);
                send_tick(1'b1);
                send_advances(k);
            end
            else if (kind < 85)
            begin
                k = $urandom_range(side_now() * side_now());
                send_tick(1'b1);
                send_advances(k);
            end
            else if (kind < 93)
            begin
                k = $urandom_range(side_now() * side_now());
                send_tick(1'b1);
                send_advances(k);
                settle();
                write_any_reg();
                guard = 0;
                while (walking && guard < 1100)
                begin
                    send_tick(1'b0);
                    guard++;
                end
            end
            else
            begin
                repeat ($urandom_range(5, 1)) send_tick(1'($urandom_range(1)));
            end
        end
        settle();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 29);
        end
    end

    // a result seen with tready high here is the transfer at the next edge
    always @(negedge clk)
    begin
        grid_pos_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cells.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d value %0d",
                       m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W],
                       m_tdata[2*POS_W+VALUE_W-1:2*POS_W]);
                mismatch_count++;
            end
            else
            begin
                want = pending_cells.pop_front();
                if (m_tdata[POS_W-1:0] !== want.row)
                begin
                    $error("row: expected %0d, actual %0d", want.row, m_tdata[POS_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[2*POS_W-1:POS_W] !== want.col)
                begin
                    $error("col: expected %0d, actual %0d", want.col,
                           m_tdata[2*POS_W-1:POS_W]);
                    mismatch_count++;
                end
                if (m_tdata[2*POS_W+VALUE_W-1:2*POS_W] !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value,
                           m_tdata[2*POS_W+VALUE_W-1:2*POS_W]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_advance();
        test_start_cells();
        test_small_square();
        test_range_clamp();
        test_live_registers();
        test_full_rate();
        test_back_pressure();
        test_random();
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("spiral_order_address_generator_top_tb OK");
        else
            $display("spiral_order_address_generator_top_tb NOT OK");
        $finish;
    end

endmodule
